/* rtl/core/msseq_pkg.sv */
// Package for the motor spool sequencer: fixed-point constants, spool mode
// and register index codes, and small saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package msseq_pkg;

	// Q format of the ramps: ONE stands for 1.0
	localparam int FRACTION_BITS = 15;
	localparam int VAL_W = 16;
	localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRACTION_BITS);

	// Working width for ramp sums and differences, signed with headroom
	localparam int CALC_W = VAL_W + 3;
	typedef logic signed [CALC_W-1:0] calc_t;

	localparam int TIMER_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_UP_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAFE_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PWM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_SPIN = 3'd4;

	// Requested spool modes; the unused code acts as shut down
	localparam logic [1:0] WANT_SHUT_DOWN = 2'd0;
	localparam logic [1:0] WANT_GROUND_IDLE = 2'd1;
	localparam logic [1:0] WANT_UNLIMITED = 2'd2;
	localparam logic [1:0] WANT_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		MODE_SHUT_DOWN = 3'd0,
		MODE_GROUND_IDLE = 3'd1,
		MODE_SPOOLING_UP = 3'd2,
		MODE_UNLIMITED = 3'd3,
		MODE_SPOOLING_DOWN = 3'd4
	} mode_t;

	// Limit a Q1.15 word to 1.0
	function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

	// Per-tick step: zero acts as the smallest step, large values saturate
	function automatic logic [VAL_W-1:0] step_of(input logic [VAL_W-1:0] v);
		return (v == '0) ? VAL_W'(1) : sat_one(v);
	endfunction

	// Widen an unsigned Q1.15 word into the signed working width
	function automatic calc_t ext(input logic [VAL_W-1:0] v);
		return calc_t'({3'b000, v});
	endfunction

	// Saturate a working value to 0..1.0
	function automatic logic [VAL_W-1:0] clamp01(input calc_t v);
		logic [VAL_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > ext(ONE)) begin
			r = ONE;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/motor_spool_sequencer.sv */
// A tick passes the input register, then the state/result register, whose
// result is then valid. One tick per cycle unless out_ready stalls the result
// channel, set by the state update loop through the mode and ramp registers.
// Reset (arst_n low, asynchronous): mode shut down, timer and ramps zero,
// configuration registers at their defaults, both pipeline slots empty.
// Depends on msseq_pkg.
`timescale 1ns / 1ps

module motor_spool_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [msseq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [msseq_pkg::CFG_DATA_W-1:0]  cfg_data,
	// tick input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              is_armed,
	input  logic                              interlock_on,
	input  logic [1:0]                        wanted_mode,
	input  logic [15:0]                       pilot_throttle,
	input  logic [15:0]                       ceiling_limit,
	input  logic                              spoolup_blocked,
	input  logic                              boost_active,
	input  logic                              thrust_is_balanced,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        spool_mode,
	output logic [15:0]                       spin_ratio,
	output logic [15:0]                       thrust_ceiling,
	output logic [15:0]                       boost_level,
	output logic                              axes_limited
);

	localparam int VW = msseq_pkg::VAL_W;
	localparam int TW = msseq_pkg::TIMER_W;

	// configuration registers
	logic [VW-1:0] up_step_q, down_step_q, arm_spin_q;
	logic [TW-1:0] safe_ticks_q;
	logic          hold_pwm_q;

	// input stage
	logic          valid_s1;
	logic          armed_s1, inter_s1, blocked_s1, boost_s1, balanced_s1;
	logic [1:0]    want_s1;
	logic [VW-1:0] thr_s1, lim_s1;

	// spool state, which is also the result register
	msseq_pkg::mode_t mode_q, mode_d;
	logic [TW-1:0]    timer_q, timer_d;
	logic [VW-1:0]    spin_q, spin_d, ceil_q, ceil_d, boost_q, boost_d;
	logic             limited_q, limited_d;
	logic             out_valid_q;

	logic advance, take_in;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign take_in   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_step_q    <= VW'(164);
			down_step_q  <= VW'(164);
			safe_ticks_q <= TW'(400);
			hold_pwm_q   <= 1'b0;
			arm_spin_q   <= VW'(21845);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				msseq_pkg::CFG_UP_STEP:    up_step_q    <= cfg_data[VW-1:0];
				msseq_pkg::CFG_DOWN_STEP:  down_step_q  <= cfg_data[VW-1:0];
				msseq_pkg::CFG_SAFE_TICKS: safe_ticks_q <= cfg_data[TW-1:0];
				msseq_pkg::CFG_HOLD_PWM:   hold_pwm_q   <= cfg_data[0];
				msseq_pkg::CFG_ARM_SPIN:   arm_spin_q   <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			armed_s1    <= is_armed;
			inter_s1    <= interlock_on;
			want_s1     <= wanted_mode;
			thr_s1      <= msseq_pkg::sat_one(pilot_throttle);
			lim_s1      <= msseq_pkg::sat_one(ceiling_limit);
			blocked_s1  <= spoolup_blocked;
			boost_s1    <= boost_active;
			balanced_s1 <= thrust_is_balanced;
		end
	end

	// next state for one tick
	always_comb begin
		logic [VW-1:0]        up, dn, m;
		logic [1:0]           want;
		logic                 force_sd;
		msseq_pkg::mode_t     mode_cur;
		msseq_pkg::calc_t     t, d;

		up = msseq_pkg::step_of(up_step_q);
		dn = msseq_pkg::step_of(down_step_q);
		m  = (thr_s1 < lim_s1) ? thr_s1 : lim_s1;
		t  = '0;
		d  = '0;

		// arming safety timer
		if (armed_s1) begin
			if (hold_pwm_q && (timer_q < safe_ticks_q)) begin
				timer_d = timer_q + TW'(1);
			end else begin
				timer_d = safe_ticks_q;
			end
		end else begin
			timer_d = '0;
		end

		// disarm or interlock off forces shutdown
		force_sd = !armed_s1 || !inter_s1;
		want     = (force_sd || (want_s1 == msseq_pkg::WANT_UNUSED))
			? msseq_pkg::WANT_SHUT_DOWN : want_s1;
		mode_cur = force_sd ? msseq_pkg::MODE_SHUT_DOWN : mode_q;

		mode_d    = mode_cur;
		spin_d    = spin_q;
		ceil_d    = ceil_q;
		boost_d   = boost_q;
		limited_d = 1'b0;

		unique case (mode_cur)
			msseq_pkg::MODE_GROUND_IDLE: begin
				limited_d = 1'b1;
				if (want == msseq_pkg::WANT_SHUT_DOWN) begin
					t = msseq_pkg::ext(spin_q) - msseq_pkg::ext(dn);
					if (t <= 0) begin
						spin_d = '0;
						mode_d = msseq_pkg::MODE_SHUT_DOWN;
					end else begin
						spin_d = t[VW-1:0];
					end
				end else if (want == msseq_pkg::WANT_UNLIMITED) begin
					t = msseq_pkg::ext(spin_q) + msseq_pkg::ext(up);
					if (t >= msseq_pkg::ext(msseq_pkg::ONE)) begin
						spin_d = msseq_pkg::ONE;
						if (!blocked_s1) begin
							mode_d = msseq_pkg::MODE_SPOOLING_UP;
						end
					end else begin
						spin_d = t[VW-1:0];
					end
				end else begin
					// slew toward the ground idle target
					d = msseq_pkg::ext(msseq_pkg::sat_one(arm_spin_q)) - msseq_pkg::ext(spin_q);
					if (d < -msseq_pkg::ext(dn)) begin
						d = -msseq_pkg::ext(dn);
					end
					if (d > msseq_pkg::ext(up)) begin
						d = msseq_pkg::ext(up);
					end
					spin_d = msseq_pkg::clamp01(msseq_pkg::ext(spin_q) + d);
				end
				ceil_d  = '0;
				boost_d = '0;
			end
			msseq_pkg::MODE_SPOOLING_UP: begin
				if (want != msseq_pkg::WANT_UNLIMITED) begin
					mode_d = msseq_pkg::MODE_SPOOLING_DOWN;
				end else begin
					spin_d = msseq_pkg::ONE;
					t = msseq_pkg::ext(ceil_q) + msseq_pkg::ext(up);
					if (t >= msseq_pkg::ext(m)) begin
						ceil_d = lim_s1;
						mode_d = msseq_pkg::MODE_UNLIMITED;
					end else begin
						ceil_d = msseq_pkg::clamp01(t);
					end
					boost_d = msseq_pkg::clamp01(msseq_pkg::ext(boost_q) - msseq_pkg::ext(up));
				end
			end
			msseq_pkg::MODE_UNLIMITED: begin
				if (want != msseq_pkg::WANT_UNLIMITED) begin
					mode_d = msseq_pkg::MODE_SPOOLING_DOWN;
				end else begin
					spin_d = msseq_pkg::ONE;
					ceil_d = lim_s1;
					if (boost_s1 && !balanced_s1) begin
						boost_d = msseq_pkg::clamp01(msseq_pkg::ext(boost_q)
							+ msseq_pkg::ext(up));
					end else begin
						boost_d = msseq_pkg::clamp01(msseq_pkg::ext(boost_q)
							- msseq_pkg::ext(up));
					end
				end
			end
			msseq_pkg::MODE_SPOOLING_DOWN: begin
				if (want == msseq_pkg::WANT_UNLIMITED) begin
					mode_d = msseq_pkg::MODE_SPOOLING_UP;
				end else begin
					spin_d = msseq_pkg::ONE;
					t = msseq_pkg::ext(ceil_q) - msseq_pkg::ext(dn);
					if (t <= 0) begin
						t = '0;
					end
					// a zero limit holds the ceiling at zero without leaving
					if (t >= msseq_pkg::ext(lim_s1)) begin
						ceil_d = lim_s1;
					end else begin
						ceil_d = t[VW-1:0];
						if (t == 0) begin
							mode_d = msseq_pkg::MODE_GROUND_IDLE;
						end
					end
					boost_d = msseq_pkg::clamp01(msseq_pkg::ext(boost_q) - msseq_pkg::ext(dn));
				end
			end
			default: begin
				// shut down
				limited_d = 1'b1;
				if ((want != msseq_pkg::WANT_SHUT_DOWN) && (timer_d >= safe_ticks_q)) begin
					mode_d = msseq_pkg::MODE_GROUND_IDLE;
				end else begin
					mode_d  = msseq_pkg::MODE_SHUT_DOWN;
					spin_d  = '0;
					ceil_d  = '0;
					boost_d = '0;
				end
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= msseq_pkg::MODE_SHUT_DOWN;
			timer_q     <= '0;
			spin_q      <= '0;
			ceil_q      <= '0;
			boost_q     <= '0;
			limited_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q    <= mode_d;
				timer_q   <= timer_d;
				spin_q    <= spin_d;
				ceil_q    <= ceil_d;
				boost_q   <= boost_d;
				limited_q <= limited_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign spool_mode     = mode_q;
	assign spin_ratio     = spin_q;
	assign thrust_ceiling = ceil_q;
	assign boost_level    = boost_q;
	assign axes_limited   = limited_q;

endmodule

/* tb/motor_spool_sequencer_test.sv */
// Self-checking testbench for motor_spool_sequencer: a directed tick table, then
// random phases under several register setups and idle patterns.
// Depends on msseq_pkg and the motor_spool_sequencer RTL.
`timescale 1ns / 1ps

module motor_spool_sequencer_test;

	localparam int UNITY = int'(msseq_pkg::ONE);
	localparam int DIR_N = 26;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_TICKS = 200;

	// One control tick as driven on the input channel
	typedef struct packed {
		logic        armed;
		logic        inter;
		logic [1:0]  want;
		logic [15:0] thr;
		logic [15:0] lim;
		logic        blocked;
		logic        boost;
		logic        balanced;
	} tick_t;

	localparam int TICK_W = $bits(tick_t);

	// One result transaction
	typedef struct packed {
		msseq_pkg::mode_t mode;
		logic [15:0]      spin;
		logic [15:0]      ceiling;
		logic [15:0]      boost;
		logic             limited;
	} spool_res_t;

	// Register setup, one field per configuration register
	typedef struct packed {
		logic [15:0] up;
		logic [15:0] down;
		logic [11:0] safe;
		logic        hold;
		logic [15:0] arm;
	} cfg_set_t;

	// Directed row: optional setup to load first, the tick, and whether the
	// result is the plain shut-down result typed in below
	typedef struct packed {
		logic [1:0] setup;
		tick_t      tick;
		logic       pinned;
	} dir_row_t;

	localparam spool_res_t SHUT_RESULT =
		'{msseq_pkg::MODE_SHUT_DOWN, 16'd0, 16'd0, 16'd0, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [msseq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [msseq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_ready;
	tick_t tick_drv = '0;
	logic pinned_drv = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] spool_mode;
	logic [15:0] spin_ratio;
	logic [15:0] thrust_ceiling;
	logic [15:0] boost_level;
	logic axes_limited;

	// Shadow registers and spool state of the predictor, at reset values
	logic [15:0] set_up = 16'd164;
	logic [15:0] set_down = 16'd164;
	logic [11:0] set_safe = 12'd400;
	logic set_hold = 1'b0;
	logic [15:0] set_arm = 16'd21845;
	msseq_pkg::mode_t sq_mode = msseq_pkg::MODE_SHUT_DOWN;
	logic [11:0] sq_timer = '0;
	logic [15:0] sq_spin = '0;
	logic [15:0] sq_ceiling = '0;
	logic [15:0] sq_boost = '0;

	spool_res_t pending_spool[$];
	int mismatches = 0;
	int results_seen = 0;
	int ticks_sent = 0;
	int setups = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	// Random tick scenario: wanted mode held for runs of ticks
	logic [1:0] run_want = msseq_pkg::WANT_SHUT_DOWN;
	int run_left = 0;
	logic run_ok = 1'b1;

	dir_row_t dir_rows [DIR_N];
	cfg_set_t dir_cfgs [1:3];

	motor_spool_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.is_armed(tick_drv.armed),
		.interlock_on(tick_drv.inter),
		.wanted_mode(tick_drv.want),
		.pilot_throttle(tick_drv.thr),
		.ceiling_limit(tick_drv.lim),
		.spoolup_blocked(tick_drv.blocked),
		.boost_active(tick_drv.boost),
		.thrust_is_balanced(tick_drv.balanced),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.spool_mode(spool_mode),
		.spin_ratio(spin_ratio),
		.thrust_ceiling(thrust_ceiling),
		.boost_level(boost_level),
		.axes_limited(axes_limited)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unit_clamp(input int v);
		return (v < 0) ? 0 : ((v > UNITY) ? UNITY : v);
	endfunction

	function automatic int sat_unity(input logic [15:0] v);
		return (v > msseq_pkg::ONE) ? UNITY : int'(v);
	endfunction

	// Advance the spool state by one tick and return the expected result
	function automatic spool_res_t spool_tick(input tick_t t);
		spool_res_t r;
		int thr, lim, up, dn, spin_v, ceil_v, boost_v, d, m;
		logic [1:0] want;
		logic lim_flag;
		thr = sat_unity(t.thr);
		lim = sat_unity(t.lim);
		up = (set_up == '0) ? 1 : sat_unity(set_up);
		dn = (set_down == '0) ? 1 : sat_unity(set_down);
		spin_v = int'(sq_spin);
		ceil_v = int'(sq_ceiling);
		boost_v = int'(sq_boost);
		lim_flag = 1'b0;

		// arming safety timer
		if (t.armed) begin
			if (set_hold && sq_timer < set_safe)
				sq_timer = sq_timer + 12'd1;
			else
				sq_timer = set_safe;
		end else begin
			sq_timer = '0;
		end

		want = t.want;
		if (want == msseq_pkg::WANT_UNUSED)
			want = msseq_pkg::WANT_SHUT_DOWN;
		if (!t.armed || !t.inter) begin
			want = msseq_pkg::WANT_SHUT_DOWN;
			sq_mode = msseq_pkg::MODE_SHUT_DOWN;
		end

		case (sq_mode)
			msseq_pkg::MODE_GROUND_IDLE: begin
				lim_flag = 1'b1;
				if (want == msseq_pkg::WANT_SHUT_DOWN) begin
					spin_v = spin_v - dn;
					if (spin_v <= 0) begin
						spin_v = 0;
						sq_mode = msseq_pkg::MODE_SHUT_DOWN;
					end
				end else if (want == msseq_pkg::WANT_UNLIMITED) begin
					spin_v = spin_v + up;
					if (spin_v >= UNITY) begin
						spin_v = UNITY;
						if (!t.blocked)
							sq_mode = msseq_pkg::MODE_SPOOLING_UP;
					end
				end else begin
					// move toward the armed spin target, rate limited both ways
					d = sat_unity(set_arm) - spin_v;
					if (d < -dn) d = -dn;
					if (d > up) d = up;
					spin_v = unit_clamp(spin_v + d);
				end
				ceil_v = 0;
				boost_v = 0;
			end
			msseq_pkg::MODE_SPOOLING_UP: begin
				if (want != msseq_pkg::WANT_UNLIMITED) begin
					sq_mode = msseq_pkg::MODE_SPOOLING_DOWN;
				end else begin
					spin_v = UNITY;
					ceil_v = ceil_v + up;
					m = (thr < lim) ? thr : lim;
					if (ceil_v >= m) begin
						ceil_v = lim;
						sq_mode = msseq_pkg::MODE_UNLIMITED;
					end
					ceil_v = unit_clamp(ceil_v);
					boost_v = unit_clamp(boost_v - up);
				end
			end
			msseq_pkg::MODE_UNLIMITED: begin
				if (want != msseq_pkg::WANT_UNLIMITED) begin
					sq_mode = msseq_pkg::MODE_SPOOLING_DOWN;
				end else begin
					spin_v = UNITY;
					ceil_v = lim;
					if (t.boost && !t.balanced)
						boost_v = unit_clamp(boost_v + up);
					else
						boost_v = unit_clamp(boost_v - up);
				end
			end
			msseq_pkg::MODE_SPOOLING_DOWN: begin
				if (want == msseq_pkg::WANT_UNLIMITED) begin
					sq_mode = msseq_pkg::MODE_SPOOLING_UP;
				end else begin
					spin_v = UNITY;
					ceil_v = ceil_v - dn;
					if (ceil_v <= 0) ceil_v = 0;
					// a zero limit pins the ceiling and keeps spooling down
					if (ceil_v >= lim)
						ceil_v = lim;
					else if (ceil_v == 0)
						sq_mode = msseq_pkg::MODE_GROUND_IDLE;
					boost_v = unit_clamp(boost_v - dn);
				end
			end
			default: begin
				sq_mode = msseq_pkg::MODE_SHUT_DOWN;
				lim_flag = 1'b1;
				if (want != msseq_pkg::WANT_SHUT_DOWN && sq_timer >= set_safe) begin
					sq_mode = msseq_pkg::MODE_GROUND_IDLE;
				end else begin
					spin_v = 0;
					ceil_v = 0;
					boost_v = 0;
				end
			end
		endcase

		sq_spin = spin_v[15:0];
		sq_ceiling = ceil_v[15:0];
		sq_boost = boost_v[15:0];
		r.mode = sq_mode;
		r.spin = sq_spin;
		r.ceiling = sq_ceiling;
		r.boost = sq_boost;
		r.limited = lim_flag;
		return r;
	endfunction

	function automatic tick_t tk(input logic armed, input logic inter, input logic [1:0] want,
			input logic [15:0] thr, input logic [15:0] lim, input logic blocked,
			input logic boost, input logic balanced);
		tick_t t;
		t = '{armed, inter, want, thr, lim, blocked, boost, balanced};
		return t;
	endfunction

	function automatic dir_row_t row(input logic [1:0] setup, input tick_t t, input logic pin);
		dir_row_t d;
		d = '{setup, t, pin};
		return d;
	endfunction

	// Q1.15 value biased toward 0, 1.0 and out-of-range words
	function automatic logic [15:0] pick_q15();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = msseq_pkg::ONE;
			2: v = 16'($urandom());
			default: v = 16'($urandom_range(0, UNITY));
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_step();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'($urandom_range(0, 16));
			1: v = 16'($urandom());
			2: v = msseq_pkg::ONE;
			default: v = 16'($urandom_range(300, 8000));
		endcase
		return v;
	endfunction

	function automatic cfg_set_t rand_cfg();
		cfg_set_t c;
		c.up = pick_step();
		c.down = pick_step();
		c.safe = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 40));
		c.hold = 1'($urandom_range(0, 1));
		c.arm = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, UNITY));
		return c;
	endfunction

	// Mostly armed runs with a held wanted mode; about one tick in ten is noise
	function automatic tick_t rand_tick();
		tick_t t;
		if (run_left == 0) begin
			run_left = $urandom_range(1, 60);
			case ($urandom_range(0, 9))
				0: run_want = msseq_pkg::WANT_SHUT_DOWN;
				1, 2: run_want = msseq_pkg::WANT_GROUND_IDLE;
				3: run_want = msseq_pkg::WANT_UNUSED;
				default: run_want = msseq_pkg::WANT_UNLIMITED;
			endcase
			run_ok = ($urandom_range(0, 9) != 0);
		end
		run_left--;
		if ($urandom_range(0, 9) == 0) begin
			t = tick_t'(TICK_W'({$urandom(), $urandom()}));
		end else begin
			t.armed = run_ok ? ($urandom_range(0, 99) != 0) : 1'($urandom_range(0, 1));
			t.inter = run_ok ? ($urandom_range(0, 99) != 0) : 1'($urandom_range(0, 1));
			t.want = run_want;
			t.thr = pick_q15();
			t.lim = pick_q15();
			t.blocked = ($urandom_range(0, 4) == 0);
			t.boost = ($urandom_range(0, 2) != 0);
			t.balanced = ($urandom_range(0, 3) == 0);
		end
		return t;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
		end
	endtask

	// Scoreboard: retire results, shadow register writes, predict accepted ticks
	always @(posedge clk) begin
		spool_res_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_spool.size() == 0) begin
					mismatches++;
					$error("result transaction with no tick pending, spool_mode %0d",
						spool_mode);
				end else begin
					due = pending_spool.pop_front();
					check_field("spool_mode", 16'(due.mode), 16'(spool_mode));
					check_field("spin_ratio", due.spin, spin_ratio);
					check_field("thrust_ceiling", due.ceiling, thrust_ceiling);
					check_field("boost_level", due.boost, boost_level);
					check_field("axes_limited", 16'(due.limited), 16'(axes_limited));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					msseq_pkg::CFG_UP_STEP: set_up = cfg_data;
					msseq_pkg::CFG_DOWN_STEP: set_down = cfg_data;
					msseq_pkg::CFG_SAFE_TICKS: set_safe = cfg_data[msseq_pkg::TIMER_W-1:0];
					msseq_pkg::CFG_HOLD_PWM: set_hold = cfg_data[0];
					msseq_pkg::CFG_ARM_SPIN: set_arm = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				due = spool_tick(tick_drv);
				if (pinned_drv)
					due = SHUT_RESULT;
				pending_spool.push_back(due);
				ticks_sent++;
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

	task automatic push_tick(input tick_t t, input logic pin);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		tick_drv <= t;
		pinned_drv <= pin;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected result has been retired
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_spool.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [msseq_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_config(input cfg_set_t c);
		wait_drained();
		write_reg(msseq_pkg::CFG_UP_STEP, c.up);
		write_reg(msseq_pkg::CFG_DOWN_STEP, c.down);
		write_reg(msseq_pkg::CFG_SAFE_TICKS, 16'(c.safe));
		write_reg(msseq_pkg::CFG_HOLD_PWM, 16'(c.hold));
		write_reg(msseq_pkg::CFG_ARM_SPIN, c.arm);
		cfg_valid <= 1'b0;
		setups++;
	endtask

	task automatic set_idling(input int sel);
		case (sel)
			0: begin tx_idle_pct = 0; rx_stall_pct <= 0; end
			1: begin tx_idle_pct = 56; rx_stall_pct <= 0; end
			2: begin tx_idle_pct = 0; rx_stall_pct <= 56; end
			default: begin tx_idle_pct = 10; rx_stall_pct <= 10; end
		endcase
	endtask

	// Main sequence
	initial begin
		cfg_set_t c;
		// setup 1: every step and the spin target above 1.0, no safety delay
		dir_cfgs[1] = '{16'hFFFF, 16'hFFFF, 12'd0, 1'b0, 16'hFFFF};
		// setup 2: zero steps, short safety delay
		dir_cfgs[2] = '{16'd0, 16'd0, 12'd3, 1'b1, 16'd0};
		// setup 3: safe_ticks below the running timer
		dir_cfgs[3] = '{msseq_pkg::ONE, 16'd1, 12'd1, 1'b1, msseq_pkg::ONE};
		dir_rows = '{
			row(0, tk(0, 1, msseq_pkg::WANT_UNLIMITED, 16'hFFFF, 16'hFFFF, 1, 1, 1), 1),
			row(1, tk(1, 0, msseq_pkg::WANT_UNLIMITED, 16'd0, 16'd0, 0, 0, 0), 1),
			row(0, tk(1, 1, msseq_pkg::WANT_UNUSED, 16'd0, 16'd0, 0, 0, 0), 1),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'd0, 16'd0, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, 16'd0, 16'd0, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'd0, 16'd0, 1, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 1, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 1, 1), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'h7FFF, msseq_pkg::ONE,
				0, 1, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, msseq_pkg::ONE, 16'd0,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_SHUT_DOWN, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_SHUT_DOWN, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_SHUT_DOWN, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(2, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_GROUND_IDLE, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(3, tk(1, 1, msseq_pkg::WANT_UNLIMITED, msseq_pkg::ONE, msseq_pkg::ONE,
				0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_UNLIMITED, 16'd0, 16'd0, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_SHUT_DOWN, 16'd0, msseq_pkg::ONE, 0, 0, 0), 0),
			row(0, tk(1, 1, msseq_pkg::WANT_SHUT_DOWN, 16'd0, 16'd0, 0, 0, 0), 0),
			row(0, tk(0, 0, msseq_pkg::WANT_SHUT_DOWN, 16'd0, 16'd0, 0, 0, 0), 1)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		set_idling(0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].setup != 2'd0)
				load_config(dir_cfgs[dir_rows[i].setup]);
			push_tick(dir_rows[i].tick, dir_rows[i].pinned);
		end

		// random phases: the first two at the register extremes
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0)
				c = '{16'd1, 16'd1, 12'd0, 1'b0, 16'd0};
			else if (p == 1)
				c = '{msseq_pkg::ONE, msseq_pkg::ONE, 12'hFFF, 1'b0, msseq_pkg::ONE};
			else
				c = rand_cfg();
			load_config(c);
			set_idling(p % 4);
			repeat (PHASE_TICKS)
				push_tick(rand_tick(), 1'b0);
		end

		set_idling(0);
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d ticks (%0d from the directed table) over %0d register setups,",
			ticks_sent, DIR_N, setups);
		$display("with %0d result transactions checked under four idle patterns.",
			results_seen);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Timeout with %0d results still pending", pending_spool.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
